### rtl/core/cfd_pkg.sv
// Shared types and constants for the control frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package cfd_pkg;

    // Frame delimiter and slot id letters
    localparam logic [7:0] END_BYTE = 8'h2D;  // '-'
    localparam logic [7:0] ID_ARM   = 8'h53;  // 'S'
    localparam logic [7:0] ID_THR   = 8'h54;  // 'T'
    localparam logic [7:0] ID_ROLL  = 8'h52;  // 'R'
    localparam logic [7:0] ID_PITCH = 8'h50;  // 'P'
    localparam logic [7:0] ID_YAW   = 8'h59;  // 'Y'

    // Report for each byte: no frame end, frame taken, frame dropped for length
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_DROP   = 2'd2
    } t_frame_event;

    // Position of a byte within its three-byte slot
    typedef enum logic [1:0] {
        PH_ID = 2'd0,
        PH_HI = 2'd1,
        PH_LO = 2'd2
    } t_slot_phase;

    // One result: committed setpoints after a byte, plus the frame report
    typedef struct packed {
        logic               armed;
        logic signed [15:0] thrust;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw_rate;
        t_frame_event       frame_event;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/cfd_frame_parser.sv
// Byte counter, per-slot decoder and committed setpoint registers.
// Depends on cfd_pkg for id codes, slot phases and the result struct.
`default_nettype none

module cfd_frame_parser #(
    parameter int NUM_SLOTS = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire logic [7:0]      i_byte,
    output cfd_pkg::t_result     o_result
);
    import cfd_pkg::*;

    localparam int DATA_LEN  = NUM_SLOTS * 3;
    localparam int OVER_MARK = DATA_LEN + 1;
    localparam int CW        = $clog2(OVER_MARK + 1);

    // Frame position
    logic [CW-1:0]      r_count, n_count;
    t_slot_phase        r_phase, n_phase;
    // Id and high byte of the slot in progress
    logic [7:0]         r_id, n_id;
    logic [7:0]         r_hi, n_hi;
    // Values of the frame being received
    logic signed [15:0] r_sh_thr, n_sh_thr;
    logic signed [15:0] r_sh_roll, n_sh_roll;
    logic signed [15:0] r_sh_pitch, n_sh_pitch;
    logic signed [15:0] r_sh_yaw, n_sh_yaw;
    logic               r_sh_arm_seen, n_sh_arm_seen;
    logic               r_sh_arm, n_sh_arm;
    // Committed setpoints
    logic               r_armed, n_armed;
    logic signed [15:0] r_thr, n_thr;
    logic signed [15:0] r_roll, n_roll;
    logic signed [15:0] r_pitch, n_pitch;
    logic signed [15:0] r_yaw, n_yaw;
    t_frame_event       n_event;
    logic [15:0]        slot_val;

    assign slot_val = {r_hi, i_byte};

    // Advance the frame, decode completed slots, commit on a full-length frame
    always_comb begin
        n_count       = r_count;
        n_phase       = r_phase;
        n_id          = r_id;
        n_hi          = r_hi;
        n_sh_thr      = r_sh_thr;
        n_sh_roll     = r_sh_roll;
        n_sh_pitch    = r_sh_pitch;
        n_sh_yaw      = r_sh_yaw;
        n_sh_arm_seen = r_sh_arm_seen;
        n_sh_arm      = r_sh_arm;
        n_armed       = r_armed;
        n_thr         = r_thr;
        n_roll        = r_roll;
        n_pitch       = r_pitch;
        n_yaw         = r_yaw;
        n_event       = EV_NONE;
        if (i_load) begin
            if (i_byte == END_BYTE) begin
                if (r_count == CW'(DATA_LEN)) begin
                    n_event = EV_ACCEPT;
                    n_thr   = r_sh_thr;
                    n_roll  = r_sh_roll;
                    n_pitch = r_sh_pitch;
                    n_yaw   = r_sh_yaw;
                    if (r_sh_arm_seen) begin
                        n_armed = r_sh_arm;
                    end
                end else begin
                    n_event = EV_DROP;
                end
                n_count       = '0;
                n_phase       = PH_ID;
                n_sh_thr      = '0;
                n_sh_roll     = '0;
                n_sh_pitch    = '0;
                n_sh_yaw      = '0;
                n_sh_arm_seen = 1'b0;
                n_sh_arm      = 1'b0;
            end else if (r_count < CW'(DATA_LEN)) begin
                n_count = CW'(r_count + 1'b1);
                unique case (r_phase)
                    PH_ID: begin
                        n_id    = i_byte;
                        n_phase = PH_HI;
                    end
                    PH_HI: begin
                        n_hi    = i_byte;
                        n_phase = PH_LO;
                    end
                    PH_LO: begin
                        n_phase = PH_ID;
                        // Later slot with the same id overwrites
                        unique case (r_id)
                            ID_ARM: begin
                                n_sh_arm_seen = 1'b1;
                                n_sh_arm      = (slot_val != 16'd0);
                            end
                            ID_THR:   n_sh_thr   = slot_val;
                            ID_ROLL:  n_sh_roll  = slot_val;
                            ID_PITCH: n_sh_pitch = slot_val;
                            ID_YAW:   n_sh_yaw   = slot_val;
                            default: ;
                        endcase
                    end
                    default: n_phase = PH_ID;
                endcase
            end else begin
                // Overlong frame: drop the byte, mark for rejection
                n_count = CW'(OVER_MARK);
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_phase       <= PH_ID;
            r_sh_thr      <= '0;
            r_sh_roll     <= '0;
            r_sh_pitch    <= '0;
            r_sh_yaw      <= '0;
            r_sh_arm_seen <= 1'b0;
            r_sh_arm      <= 1'b0;
            r_armed       <= 1'b0;
            r_thr         <= '0;
            r_roll        <= '0;
            r_pitch       <= '0;
            r_yaw         <= '0;
        end else begin
            r_count       <= n_count;
            r_phase       <= n_phase;
            r_sh_thr      <= n_sh_thr;
            r_sh_roll     <= n_sh_roll;
            r_sh_pitch    <= n_sh_pitch;
            r_sh_yaw      <= n_sh_yaw;
            r_sh_arm_seen <= n_sh_arm_seen;
            r_sh_arm      <= n_sh_arm;
            r_armed       <= n_armed;
            r_thr         <= n_thr;
            r_roll        <= n_roll;
            r_pitch       <= n_pitch;
            r_yaw         <= n_yaw;
        end
    end

    // Slot bytes in progress
    always_ff @(posedge i_clk) begin
        r_id <= n_id;
        r_hi <= n_hi;
    end

    // Result for this byte, as seen after it is taken
    always_comb begin
        o_result.armed       = n_armed;
        o_result.thrust      = n_thr;
        o_result.roll        = n_roll;
        o_result.pitch       = n_pitch;
        o_result.yaw_rate    = n_yaw;
        o_result.frame_event = n_event;
    end

endmodule

`default_nettype wire

### rtl/core/cfd_out_reg.sv
// Result register with valid flag between the parser and the output stream.
// Depends on cfd_pkg for the result struct.
`default_nettype none

module cfd_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  cfd_pkg::t_result     i_result,
    input  wire logic            i_take,
    output logic                 o_valid,
    output cfd_pkg::t_result     o_result
);
    import cfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Hold a result until taken; load replaces it in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

### rtl/core/control_frame_deframer_unit.sv
// Top level of the control frame deframer: byte stream in, setpoint stream out.
// Depends on cfd_pkg, cfd_frame_parser and cfd_out_reg.
//
// Takes one serial byte per request and returns one result per byte in the cycle
// after the byte is taken; a byte can be taken every cycle, also while the
// previous result waits, as long as the downstream side takes that result in
// the same cycle. A '-' byte closes the frame; a frame of exactly NUM_SLOTS*3
// bytes before it updates the four raw setpoints (thrust in 0.1 units, the others
// in 0.001 units) and, given an arm slot, the armed flag; any other length
// is reported as a drop and leaves them unchanged. Slots are decoded as their
// third byte arrives, so the frame end only copies already decoded values.
`default_nettype none

module control_frame_deframer_unit #(
    parameter int NUM_SLOTS = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // [0] armed, [16:1] thrust_raw, [32:17] roll_raw,
                                          // [48:33] pitch_raw, [64:49] yaw_rate_raw, rest 0
    output logic [1:0]       o_m_tuser    // [1:0] frame_event
);
    import cfd_pkg::*;

    logic    s_acc;
    logic    m_take;
    t_result parse_res;
    t_result out_res;

    assign m_take     = o_m_tvalid && i_m_tready;
    assign o_s_tready = !o_m_tvalid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Decode bytes and keep the setpoints
    cfd_frame_parser #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_acc),
        .i_byte   (i_s_tdata),
        .o_result (parse_res)
    );

    // Register the result toward the output stream
    cfd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_acc),
        .i_result (parse_res),
        .i_take   (m_take),
        .o_valid  (o_m_tvalid),
        .o_result (out_res)
    );

    // Pack the output stream
    assign o_m_tdata = {7'd0, out_res.yaw_rate, out_res.pitch, out_res.roll,
                        out_res.thrust, out_res.armed};
    assign o_m_tuser = out_res.frame_event;

    // A data byte never reports a frame end
    a_data_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_tdata != END_BYTE) |=> o_m_tvalid && (o_m_tuser == EV_NONE))
        else $error("frame event reported for a data byte");

    // A delimiter always reports accept or drop
    a_end_has_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_tdata == END_BYTE) |=> o_m_tvalid && (o_m_tuser != EV_NONE))
        else $error("frame end without accept or drop");

    // A dropped frame leaves the setpoints as the prior result showed them
    a_drop_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_m_tvalid) && s_acc && (i_s_tdata == END_BYTE)
        && (o_m_tuser == EV_NONE || o_m_tuser == EV_DROP || o_m_tuser == EV_ACCEPT)
        ##1 (o_m_tuser == EV_DROP) |-> o_m_tdata == $past(o_m_tdata))
        else $error("dropped frame changed the setpoints");

endmodule

`default_nettype wire

### tb/cfd_result_checker.sv
// Watches both stream channels of the control frame deframer, predicts each result.
// Compares every output request against the oldest prediction. Depends on cfd_pkg.
`default_nettype none

module cfd_result_checker #(
    parameter int NUM_SLOTS = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [71:0] i_m_tdata,   // [0] armed, [16:1] thrust, [32:17] roll,
                                          // [48:33] pitch, [64:49] yaw_rate, rest 0
    input  wire logic [1:0]  i_m_tuser,   // [1:0] frame_event
    output int               o_fail_count,
    output int               o_pending
);
    import cfd_pkg::*;

    localparam int DATA_LEN = NUM_SLOTS * 3;

    // Predicted deframer state
    logic [7:0]         frame_store [DATA_LEN];
    int                 fill_count = 0;
    logic               armed_q    = 1'b0;
    logic signed [15:0] thrust_q   = '0;
    logic signed [15:0] roll_q     = '0;
    logic signed [15:0] pitch_q    = '0;
    logic signed [15:0] yaw_q      = '0;

    t_result expected_setpoints [$];
    int      result_index = 0;

    // Advance the predicted state by one byte and return the result it reports
    function automatic t_result advance_deframer(input logic [7:0] rx);
        t_result            res;
        t_frame_event       ev;
        logic signed [15:0] thr;
        logic signed [15:0] rol;
        logic signed [15:0] pit;
        logic signed [15:0] yaw;
        logic signed [15:0] val;
        ev  = EV_NONE;
        thr = '0;
        rol = '0;
        pit = '0;
        yaw = '0;
        if (rx == END_BYTE) begin
            if (fill_count == DATA_LEN) begin
                // Later slots overwrite earlier ones; unnamed setpoints fall to zero
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    val = {frame_store[3*k+1], frame_store[3*k+2]};
                    case (frame_store[3*k])
                        ID_ARM:   armed_q = (val != 0);
                        ID_THR:   thr = val;
                        ID_ROLL:  rol = val;
                        ID_PITCH: pit = val;
                        ID_YAW:   yaw = val;
                        default: ;
                    endcase
                end
                thrust_q = thr;
                roll_q   = rol;
                pitch_q  = pit;
                yaw_q    = yaw;
                ev = EV_ACCEPT;
            end else begin
                ev = EV_DROP;
            end
            fill_count = 0;
        end else if (fill_count < DATA_LEN) begin
            frame_store[fill_count] = rx;
            fill_count++;
        end else begin
            // Overlong frame: saturate and discard the byte
            fill_count = DATA_LEN + 1;
        end
        res.armed       = armed_q;
        res.thrust      = thrust_q;
        res.roll        = roll_q;
        res.pitch       = pitch_q;
        res.yaw_rate    = yaw_q;
        res.frame_event = ev;
        return res;
    endfunction

    // Predict on input requests, compare on output requests
    always @(posedge i_clk) begin
        t_result act;
        t_result exp_r;
        if (!i_rst_n) begin
            fill_count = 0;
            armed_q    = 1'b0;
            thrust_q   = '0;
            roll_q     = '0;
            pitch_q    = '0;
            yaw_q      = '0;
            expected_setpoints.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_setpoints.push_back(advance_deframer(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                act.armed       = i_m_tdata[0];
                act.thrust      = i_m_tdata[16:1];
                act.roll        = i_m_tdata[32:17];
                act.pitch       = i_m_tdata[48:33];
                act.yaw_rate    = i_m_tdata[64:49];
                act.frame_event = t_frame_event'(i_m_tuser);
                if (expected_setpoints.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("result %0d: arrived with no byte pending", result_index);
                end else begin
                    exp_r = expected_setpoints.pop_front();
                    if (act !== exp_r || i_m_tdata[71:65] !== '0) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("result %0d: exp arm=%0b thr=%0d rol=%0d pit=%0d yaw=%0d ev=%0d",
                                     result_index, exp_r.armed, exp_r.thrust, exp_r.roll,
                                     exp_r.pitch, exp_r.yaw_rate, exp_r.frame_event);
                            $display("    got arm=%0b thr=%0d rol=%0d pit=%0d yaw=%0d ev=%0d pad=%h",
                                     act.armed, act.thrust, act.roll, act.pitch,
                                     act.yaw_rate, i_m_tuser, i_m_tdata[71:65]);
                        end
                    end
                end
                result_index++;
            end
        end
        o_pending = expected_setpoints.size();
    end

endmodule

`default_nettype wire

### tb/testbench.sv
// Top of the deframer testbench: clock, reset, byte stimulus and result-side flow control.
// Depends on cfd_pkg, control_frame_deframer_unit and cfd_result_checker.
`default_nettype none

module testbench;
    import cfd_pkg::*;

    localparam int NUM_SLOTS  = 5;
    localparam int BYTE_GOAL  = 1800;
    localparam int LONG_HOLD  = 400;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int bytes_sent    = 0;
    int results_taken = 0;
    bit send_burst    = 1'b0;

    logic [7:0] slot_ids [5] = '{ID_ARM, ID_THR, ID_ROLL, ID_PITCH, ID_YAW};

    control_frame_deframer_unit #(.NUM_SLOTS(NUM_SLOTS)) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    cfd_result_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one byte, after a random gap unless in a burst, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_slot(input logic [7:0] id, input logic [15:0] val);
        send_byte(id);
        send_byte(val[15:8]);
        send_byte(val[7:0]);
    endtask

    // Any byte except the delimiter
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == END_BYTE)
            b = b ^ 8'h80;
        return b;
    endfunction

    // Pick a slot id: mostly known letters, sometimes an unknown one
    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 5) == 5)
            return body_byte();
        return slot_ids[$urandom_range(0, 4)];
    endfunction

    // Slot value free of delimiter bytes, often an extreme
    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'h0000;
            3:       v = 16'hFFFF;
            default: v = {body_byte(), body_byte()};
        endcase
        return v;
    endfunction

    // Stimulus
    initial begin
        int kind;
        int n;
        int cut;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every id, mostly with extreme values, then an empty and a short frame
        send_slot(ID_ARM,   16'h8000);
        send_slot(ID_THR,   16'h7FFF);
        send_slot(ID_ROLL,  16'h8000);
        send_slot(ID_PITCH, 16'hFFFF);
        send_slot(ID_YAW,   16'h0001);
        send_byte(END_BYTE);
        send_byte(END_BYTE);
        send_byte(8'h51);
        send_byte(8'h00);
        send_byte(END_BYTE);

        // Random frames, mostly well formed
        while (bytes_sent < BYTE_GOAL) begin
            send_burst = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                for (int k = 0; k < NUM_SLOTS; k++)
                    send_slot(pick_id(), pick_value());
                send_byte(END_BYTE);
            end else if (kind == 7) begin
                // Random length, short through overlong, at times the exact length
                n = $urandom_range(0, 22);
                repeat (n) send_byte(body_byte());
                send_byte(END_BYTE);
            end else if (kind == 8) begin
                // Noise, delimiter allowed anywhere
                n = $urandom_range(1, 8);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                send_byte(END_BYTE);
            end else begin
                // Well-formed start cut by a delimiter, often inside a value
                cut = $urandom_range(1, NUM_SLOTS * 3 - 1);
                for (int k = 0; k < cut; k++)
                    send_byte((k % 3 == 0) ? pick_id() : body_byte());
                send_byte(END_BYTE);
            end
        end
        s_tvalid <= 1'b0;

        // Let the checker record the last request before draining
        repeat (2) @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("control_frame_deframer_unit: match");
        else
            $display("control_frame_deframer_unit: mismatch");
        $finish;
    end

    // Result side: random stalls, bursts, and one long hold-off
    initial begin
        int  gap;
        bit  take_burst;
        take_burst = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (results_taken % 40 == 0)
                take_burst = ($urandom_range(0, 3) == 0);
            gap = take_burst ? 0 : $urandom_range(0, 9);
            if (results_taken == 300)
                gap = LONG_HOLD;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_taken++;
        end
    end

    // Run limit
    initial begin
        #800000;
        $display("control_frame_deframer_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
